@@ design/hsd_pkg.sv @@
// shared widths and the stored pair type for the descending heap sort
package hsd_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 8;

  // one stored entry: key with its tag
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } pair_t;

endpackage

@@ design/hsd_if.sv @@
// valid/ready channel interfaces for the input pairs and the sorted results
interface hsd_in_if;
  import hsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;
  logic             final_item;

  modport source (output valid, key, tag, final_item, input ready);
  modport sink   (input valid, key, tag, final_item, output ready);
endinterface

interface hsd_out_if;
  import hsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             last_result;

  modport source (output valid, sorted_key, sorted_tag, last_result, input ready);
  modport sink   (input valid, sorted_key, sorted_tag, last_result, output ready);
endinterface

@@ design/heap_sort_descending_pairs.sv @@
// Descending heap sort of key/tag pairs held in a two-read, one-write store.
// Load: one pair per cycle while in the load state. Heap build: each internal
// node is read, held and then sifted down one level per sift step; extraction:
// each root removal reads root and tail, swaps them and sifts the tail pair down
// from the root. Each result is read and then waits until the output is free.
// Synchronous active-low reset empties the set and the output register.
module heap_sort_descending_pairs #(
  parameter int MAX_ITEMS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hsd_in_if.sink     in_ch,
  hsd_out_if.source  out_ch
);
  import hsd_pkg::*;

  localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int CIW = AW + 2;

  typedef enum logic [7:0] {
    ST_LOAD      = 8'b0000_0001,
    ST_BUILD_RD  = 8'b0000_0010,
    ST_HOLD      = 8'b0000_0100,
    ST_SIFT      = 8'b0000_1000,
    ST_EXT_RD    = 8'b0001_0000,
    ST_EXT_SWAP  = 8'b0010_0000,
    ST_EMIT_RD   = 8'b0100_0000,
    ST_EMIT_WAIT = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [AW-1:0] bi_r, bi_nxt;
  logic [AW-1:0] ei_r, ei_nxt;
  logic          building_r, building_nxt;
  pair_t         held_r, held_nxt;
  logic          out_valid_r, out_valid_nxt;
  pair_t         out_pair_r, out_pair_nxt;
  logic          out_last_r, out_last_nxt;

  // store port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pair_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  pair_t         mem_rdata_a;
  pair_t         mem_rdata_b;

  // sift compare signals
  logic [CIW-1:0] lc_cur, rc_cur, lc_next, rc_next;
  logic           lc_ok, rc_ok;
  logic [1:0]     pick;
  logic [KEY_W-1:0] best_key;
  logic [CW-1:0]  n_load;
  logic           in_xfer, out_xfer, out_free, emit_last;

  hsd_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign in_ch.ready        = (state_r == ST_LOAD);
  assign in_xfer            = in_ch.valid && in_ch.ready;
  assign out_xfer           = out_valid_r && out_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.sorted_key  = out_pair_r.key;
  assign out_ch.sorted_tag  = out_pair_r.tag;
  assign out_ch.last_result = out_last_r;

  // set size after the current transfer, a full store drops the pair
  assign n_load = (count_r < CW'(MAX_ITEMS)) ? count_r + CW'(1) : count_r;

  assign emit_last = ((CW'(ei_r) + CW'(1)) == n_r);

  // children of the node being sifted
  assign lc_cur = {1'b0, node_r, 1'b1};
  assign rc_cur = {1'b0, node_r, 1'b0} + CIW'(2);
  assign lc_ok  = lc_cur < CIW'(len_r);
  assign rc_ok  = rc_cur < CIW'(len_r);

  // smallest of held, left, right with strict less-than, left tested first
  always_comb begin
    pick     = 2'd0;
    best_key = held_r.key;
    if (lc_ok) begin
      if (mem_rdata_a.key < best_key) begin
        pick     = 2'd1;
        best_key = mem_rdata_a.key;
      end
    end
    if (rc_ok) begin
      if (mem_rdata_b.key < best_key) begin
        pick = 2'd2;
      end
    end
  end

  // children of the node that the next sift step looks at
  assign lc_next = {1'b0, node_nxt, 1'b1};
  assign rc_next = {1'b0, node_nxt, 1'b0} + CIW'(2);

  // sequencer: load, heap build, extraction, emission
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    len_nxt       = len_r;
    node_nxt      = node_r;
    bi_nxt        = bi_r;
    ei_nxt        = ei_r;
    building_nxt  = building_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_pair_nxt  = out_pair_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = '{key: in_ch.key, tag: in_ch.tag};
    mem_re        = 1'b0;
    mem_raddr_a   = node_r;
    mem_raddr_b   = node_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          mem_we    = (count_r < CW'(MAX_ITEMS));
          count_nxt = n_load;
          if (in_ch.final_item) begin
            count_nxt = '0;
            n_nxt     = n_load;
            len_nxt   = n_load;
            ei_nxt    = '0;
            if (n_load >= CW'(2)) begin
              bi_nxt       = AW'((n_load >> 1) - CW'(1));
              building_nxt = 1'b1;
              state_nxt    = ST_BUILD_RD;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end

      ST_BUILD_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = bi_r;
        node_nxt    = bi_r;
        state_nxt   = ST_HOLD;
      end

      ST_HOLD: begin
        held_nxt  = mem_rdata_a;
        state_nxt = ST_SIFT;
      end

      ST_SIFT: begin
        mem_we    = 1'b1;
        mem_waddr = node_r;
        case (pick)
          2'd1: begin
            mem_wdata = mem_rdata_a;
            node_nxt  = lc_cur[AW-1:0];
          end
          2'd2: begin
            mem_wdata = mem_rdata_b;
            node_nxt  = rc_cur[AW-1:0];
          end
          default: begin
            mem_wdata = held_r;
            if (building_r) begin
              if (bi_r == '0) begin
                building_nxt = 1'b0;
                state_nxt    = ST_EXT_RD;
              end else begin
                bi_nxt    = bi_r - AW'(1);
                state_nxt = ST_BUILD_RD;
              end
            end else if (len_r >= CW'(2)) begin
              state_nxt = ST_EXT_RD;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end
        endcase
      end

      ST_EXT_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = '0;
        mem_raddr_b = AW'(len_r - CW'(1));
        state_nxt   = ST_EXT_SWAP;
      end

      ST_EXT_SWAP: begin
        // root goes to the tail, the tail pair is sifted from the root
        mem_we    = 1'b1;
        mem_waddr = AW'(len_r - CW'(1));
        mem_wdata = mem_rdata_a;
        held_nxt  = mem_rdata_b;
        len_nxt   = len_r - CW'(1);
        node_nxt  = '0;
        state_nxt = ST_SIFT;
      end

      ST_EMIT_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = ei_r;
        state_nxt   = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pair_nxt  = mem_rdata_a;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = ST_LOAD;
          end else begin
            ei_nxt    = ei_r + AW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // every sift step reads both children of the node it moves to
    if (state_nxt == ST_SIFT) begin
      mem_re      = 1'b1;
      mem_raddr_a = lc_next[AW-1:0];
      mem_raddr_b = rc_next[AW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      building_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      building_r  <= building_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    len_r      <= len_nxt;
    node_r     <= node_nxt;
    bi_r       <= bi_nxt;
    ei_r       <= ei_nxt;
    held_r     <= held_nxt;
    out_pair_r <= out_pair_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ design/hsd_store.sv @@
// pair store: one write port, two registered read ports
module hsd_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  hsd_pkg::pair_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr_a,
  input  logic [AW-1:0]  raddr_b,
  output hsd_pkg::pair_t rdata_a,
  output hsd_pkg::pair_t rdata_b
);
  import hsd_pkg::*;

  pair_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ design/hsd_checker.sv @@
// port-level checks for the descending heap sort, bound to the top level
module hsd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_final,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hsd_pkg::KEY_W-1:0] out_key,
  input logic [hsd_pkg::TAG_W-1:0] out_tag,
  input logic                      out_last
);
  import hsd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(out_last))
    else $error("stalled result changed");

  // no new pair is taken while a result other than the last of a set is pending
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while results of a set are pending");

  // a final pair closes the set and stops input
  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("input still ready after the final pair");

  // reset leaves an empty block ready to load
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind heap_sort_descending_pairs hsd_checker u_hsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_item),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_key   (out_ch.sorted_key),
  .out_tag   (out_ch.sorted_tag),
  .out_last  (out_ch.last_result)
);
